// ----- sv/record_slot_allocator_defines.svh -----
// Assertion macros shared by the record slot allocator.
`ifndef RECORD_SLOT_ALLOCATOR_DEFINES_SVH
`define RECORD_SLOT_ALLOCATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define RSA_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define RSA_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

// ----- sv/rsa_pkg.sv -----
// Shared types, codes and constants of the record slot allocator.
package rsa_pkg;

  localparam int unsigned MAX_PAGES_DEF = 256;
  localparam int unsigned MAX_SLOTS_DEF = 64;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PAGE_W   = 8;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned TDATA_W  = 16;
  localparam int unsigned PAD_W    = TDATA_W - PAGE_W - SLOT_W;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UPDATE = 2'd3
  } rsa_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_PAGE   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } rsa_status_e;

  // Write strobes into the page store, one per field of a page row.
  typedef struct packed {
    logic occ;
    logic cnt;
    logic link;
    logic inl;
  } rsa_wr_en_t;

  // Clamp the programmed slot count into 1..max_slots.
  function automatic int unsigned rsa_eff_slots(input logic [CFG_W-1:0] v,
                                                input int unsigned max_slots);
    int unsigned r;
    r = int'(v);
    if (r == 0) r = 1;
    if (r > max_slots) r = max_slots;
    return r;
  endfunction

endpackage

// ----- sv/record_slot_allocator.sv -----
// Record slot allocator: request channel, page store update and result register.
//
// Requests enter on the s_axis channel: tuser carries the command (insert,
// delete, read check, update check), tdata the page and slot. Results leave
// on the m_axis channel: tuser carries the status, tdata the page and slot,
// for insert the allocated ones. Every request gives exactly one result.
// The slot count per page is written on the cfg channel (always ready);
// write it only while no request is in flight.
//
// In the accept cycle the page row (bitmap, count, link, in-list flag) is
// read from the page store into registers; once the result register is free
// or being emptied, the row is updated, written back, and the result is
// registered. The block takes no new request until the current one has
// done its read-modify-write of the page row.
// The result register parts the two sides: when the receiver stalls, the
// block still accepts a new request and holds it with its row read until the
// waiting result is taken.
// Reset empties the free list and sets the page count to zero; a page row is
// cleared when its page is opened, so no clearing pass follows reset.
`include "record_slot_allocator_defines.svh"

module record_slot_allocator #(
  parameter int unsigned MAX_PAGES = rsa_pkg::MAX_PAGES_DEF,
  parameter int unsigned MAX_SLOTS = rsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] page, [13:8] slot, [15:14] zero
  input  logic [rsa_pkg::TDATA_W-1:0]   s_axis_tdata,
  // [1:0] cmd
  input  logic [rsa_pkg::CMD_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] page_out, [13:8] slot_out, [15:14] zero
  output logic [rsa_pkg::TDATA_W-1:0]   m_axis_tdata,
  // [1:0] status
  output logic [rsa_pkg::STATUS_W-1:0]  m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rsa_pkg::CFG_W-1:0]     cfg_data_i
);
  import rsa_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PAGES);
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);
  localparam int unsigned SW = $clog2(MAX_SLOTS);
  localparam int unsigned NW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned XW = (CW > PAGE_W) ? CW : PAGE_W;
  localparam int unsigned YW = (NW > SLOT_W) ? NW : SLOT_W;
  localparam logic [NW-1:0] SPP_RESET = NW'(rsa_eff_slots(CFG_RESET, MAX_SLOTS));
  localparam logic [MAX_SLOTS-1:0] SLOT_ONE = MAX_SLOTS'(1);

  // request stage
  logic          busy_q;
  rsa_cmd_e      cmd_q;
  logic [PAGE_W-1:0] page_q;
  logic [SLOT_W-1:0] slot_q;
  logic [PW-1:0] addr_q;

  // allocator state
  logic [NW-1:0] spp_q;
  logic [PW-1:0] free_head_q, free_head_d;
  logic          head_valid_q, head_valid_d;
  logic [CW-1:0] pages_in_use_q, pages_in_use_d;

  // result register
  logic              m_valid_q;
  rsa_status_e       m_status_q, res_status;
  logic [PAGE_W-1:0] m_page_q, res_page;
  logic [SLOT_W-1:0] m_slot_q, res_slot;

  logic          in_fire, exec_fire;
  rsa_cmd_e      in_cmd;
  logic [PAGE_W-1:0] in_page;
  logic [PW-1:0] rd_addr;

  rsa_wr_en_t           wr_en, wr_en_g;
  logic [MAX_SLOTS-1:0] occ_rd, occ_cur, occ_wd;
  logic [NW-1:0]        cnt_rd, cnt_cur, cnt_wd, cnt_inc;
  logic [PW:0]          link_rd, link_cur, link_wd;
  logic                 inl_rd, inl_wd;

  logic          is_ins, fresh_page, store_full, found;
  logic [SW-1:0] free_idx;
  logic          page_ok, bit_set;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = busy_q && (!m_valid_q || m_axis_tready);

  assign in_cmd  = rsa_cmd_e'(s_axis_tuser);
  assign in_page = s_axis_tdata[PAGE_W-1:0];

  // insert reads the head page, or the page about to be opened
  always_comb begin
    if (in_cmd == CMD_INSERT) begin
      rd_addr = head_valid_q ? free_head_q : pages_in_use_q[PW-1:0];
    end else begin
      rd_addr = PW'(in_page);
    end
  end

  rsa_page_store #(
    .MAX_PAGES(MAX_PAGES),
    .MAX_SLOTS(MAX_SLOTS),
    .PW       (PW),
    .NW       (NW)
  ) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (in_fire),
    .rd_addr_i(rd_addr),
    .wr_en_i  (wr_en_g),
    .wr_addr_i(addr_q),
    .occ_wd_i (occ_wd),
    .cnt_wd_i (cnt_wd),
    .link_wd_i(link_wd),
    .inl_wd_i (inl_wd),
    .occ_rd_o (occ_rd),
    .cnt_rd_o (cnt_rd),
    .link_rd_o(link_rd),
    .inl_rd_o (inl_rd)
  );

  assign is_ins     = (cmd_q == CMD_INSERT);
  assign fresh_page = !head_valid_q;
  assign store_full = fresh_page && (pages_in_use_q == CW'(MAX_PAGES));

  // a freshly opened page starts empty, whatever its row held before
  assign occ_cur  = (is_ins && fresh_page) ? '0 : occ_rd;
  assign cnt_cur  = (is_ins && fresh_page) ? '0 : cnt_rd;
  assign link_cur = (is_ins && fresh_page) ? {head_valid_q, free_head_q} : link_rd;
  assign cnt_inc  = cnt_cur + NW'(1);

  rsa_find_free #(
    .MAX_SLOTS(MAX_SLOTS),
    .SW       (SW),
    .NW       (NW)
  ) u_find (
    .occ_i  (occ_cur),
    .spp_i  (spp_q),
    .found_o(found),
    .idx_o  (free_idx)
  );

  assign page_ok = XW'(page_q) < XW'(pages_in_use_q);
  assign bit_set = (YW'(slot_q) < YW'(spp_q)) && occ_rd[slot_q[SW-1:0]];

  always_comb begin
    res_status     = ST_OK;
    res_page       = page_q;
    res_slot       = slot_q;
    wr_en          = '0;
    occ_wd         = occ_cur;
    cnt_wd         = cnt_cur;
    link_wd        = {head_valid_q, free_head_q};
    inl_wd         = 1'b0;
    free_head_d    = free_head_q;
    head_valid_d   = head_valid_q;
    pages_in_use_d = pages_in_use_q;
    unique case (cmd_q)
      CMD_INSERT: begin
        res_page = '0;
        res_slot = '0;
        if (store_full) begin
          res_status = ST_FULL;
        end else begin
          if (fresh_page) begin
            // open the next page and push it on the free list
            wr_en.occ      = 1'b1;
            wr_en.cnt      = 1'b1;
            wr_en.link     = 1'b1;
            wr_en.inl      = 1'b1;
            inl_wd         = 1'b1;
            free_head_d    = addr_q;
            head_valid_d   = 1'b1;
            pages_in_use_d = pages_in_use_q + CW'(1);
          end
          if (!found) begin
            // head page has nothing in range: drop it from the list
            res_status                  = ST_FULL;
            wr_en.inl                   = 1'b1;
            inl_wd                      = 1'b0;
            {head_valid_d, free_head_d} = link_cur;
          end else begin
            wr_en.occ = 1'b1;
            wr_en.cnt = 1'b1;
            occ_wd    = occ_cur | (SLOT_ONE << free_idx);
            cnt_wd    = cnt_inc;
            res_page  = PAGE_W'(addr_q);
            res_slot  = SLOT_W'(free_idx);
            if (cnt_inc >= spp_q) begin
              wr_en.inl                   = 1'b1;
              inl_wd                      = 1'b0;
              {head_valid_d, free_head_d} = link_cur;
            end
          end
        end
      end
      CMD_DELETE, CMD_READ, CMD_UPDATE: begin
        if (!page_ok) begin
          res_status = ST_NO_PAGE;
        end else if (!bit_set) begin
          res_status = ST_NOT_FOUND;
        end else if (cmd_q == CMD_DELETE) begin
          wr_en.occ = 1'b1;
          wr_en.cnt = 1'b1;
          occ_wd    = occ_rd & ~(SLOT_ONE << slot_q[SW-1:0]);
          cnt_wd    = (cnt_rd != '0) ? cnt_rd - NW'(1) : cnt_rd;
          if (!inl_rd) begin
            // relink a page that had been full
            wr_en.link   = 1'b1;
            wr_en.inl    = 1'b1;
            inl_wd       = 1'b1;
            free_head_d  = addr_q;
            head_valid_d = 1'b1;
          end
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign wr_en_g = exec_fire ? wr_en : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      spp_q          <= SPP_RESET;
      free_head_q    <= '0;
      head_valid_q   <= 1'b0;
      pages_in_use_q <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (exec_fire) begin
        busy_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        spp_q <= NW'(rsa_eff_slots(cfg_data_i, MAX_SLOTS));
      end
      if (exec_fire) begin
        free_head_q    <= free_head_d;
        head_valid_q   <= head_valid_d;
        pages_in_use_q <= pages_in_use_d;
      end
      if (exec_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // hold the request and the result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= in_cmd;
      page_q <= in_page;
      slot_q <= s_axis_tdata[PAGE_W +: SLOT_W];
      addr_q <= rd_addr;
    end
    if (exec_fire) begin
      m_status_q <= res_status;
      m_page_q   <= res_page;
      m_slot_q   <= res_slot;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, m_slot_q, m_page_q};

  `RSA_ASSERT_NOW(a_pages_bound, 1'b1, pages_in_use_q <= CW'(MAX_PAGES), "page count overflow")
  `RSA_ASSERT_NOW(a_head_in_use, head_valid_q, CW'(free_head_q) < pages_in_use_q, "head not open")
  `RSA_ASSERT_NEXT(a_result_out, exec_fire, m_valid_q, "result lost after execute")
  `RSA_ASSERT_NEXT(a_busy_hold, busy_q && !exec_fire, busy_q, "request dropped while stalled")

endmodule

// ----- sv/rsa_find_free.sv -----
// Lowest free slot search over one page's occupancy bitmap.
module rsa_find_free #(
  parameter int unsigned MAX_SLOTS = rsa_pkg::MAX_SLOTS_DEF,
  parameter int unsigned SW        = $clog2(MAX_SLOTS),
  parameter int unsigned NW        = $clog2(MAX_SLOTS + 1)
) (
  input  logic [MAX_SLOTS-1:0] occ_i,
  input  logic [NW-1:0]        spp_i,
  output logic                 found_o,
  output logic [SW-1:0]        idx_o
);
  import rsa_pkg::*;

  logic [MAX_SLOTS-1:0] usable;
  logic [MAX_SLOTS-1:0] free_bits;
  logic [MAX_SLOTS-1:0] lowest;

  always_comb begin
    for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
      usable[i] = (NW'(i) < spp_i);
    end
  end

  assign free_bits = ~occ_i & usable;
  // isolate the lowest set bit
  assign lowest    = free_bits & (~free_bits + MAX_SLOTS'(1));
  assign found_o   = |free_bits;

  always_comb begin
    idx_o = '0;
    for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
      if (lowest[i]) idx_o = idx_o | SW'(i);
    end
  end

endmodule

// ----- sv/rsa_page_store.sv -----
// Per-page rows: occupancy bitmap, record count, free-list link, in-list flag.
module rsa_page_store #(
  parameter int unsigned MAX_PAGES = rsa_pkg::MAX_PAGES_DEF,
  parameter int unsigned MAX_SLOTS = rsa_pkg::MAX_SLOTS_DEF,
  parameter int unsigned PW        = $clog2(MAX_PAGES),
  parameter int unsigned NW        = $clog2(MAX_SLOTS + 1)
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [PW-1:0]       rd_addr_i,
  input  rsa_pkg::rsa_wr_en_t wr_en_i,
  input  logic [PW-1:0]       wr_addr_i,
  input  logic [MAX_SLOTS-1:0] occ_wd_i,
  input  logic [NW-1:0]       cnt_wd_i,
  input  logic [PW:0]         link_wd_i,
  input  logic                inl_wd_i,
  output logic [MAX_SLOTS-1:0] occ_rd_o,
  output logic [NW-1:0]       cnt_rd_o,
  output logic [PW:0]         link_rd_o,
  output logic                inl_rd_o
);
  import rsa_pkg::*;

  logic [MAX_SLOTS-1:0] occ_mem  [MAX_PAGES];
  logic [NW-1:0]        cnt_mem  [MAX_PAGES];
  logic [PW:0]          link_mem [MAX_PAGES];
  logic                 inl_mem  [MAX_PAGES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i.occ)  occ_mem[wr_addr_i]  <= occ_wd_i;
    if (wr_en_i.cnt)  cnt_mem[wr_addr_i]  <= cnt_wd_i;
    if (wr_en_i.link) link_mem[wr_addr_i] <= link_wd_i;
    if (wr_en_i.inl)  inl_mem[wr_addr_i]  <= inl_wd_i;
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      occ_rd_o  <= occ_mem[rd_addr_i];
      cnt_rd_o  <= cnt_mem[rd_addr_i];
      link_rd_o <= link_mem[rd_addr_i];
      inl_rd_o  <= inl_mem[rd_addr_i];
    end
  end

endmodule
